// File: sv/tsm_pkg.sv
// Package for the two-way sorted merge: default sizes shared by the
// interfaces and the top level. No dependencies.
package tsm_pkg;

  localparam int unsigned ListDepthDef = 16;
  localparam int unsigned ValueBitsDef = 31;

endpackage : tsm_pkg

// File: sv/tsm_if.sv
// Valid/ready channels of the two-way sorted merge: input element channel
// and merged result channel. Depends on tsm_pkg.
interface tsm_in_if
  import tsm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [VALUE_BITS-1:0] value;
  logic                  end_of_list;

  modport source (output valid, kind, value, end_of_list, input ready);
  modport sink   (input valid, kind, value, end_of_list, output ready);
endinterface : tsm_in_if

interface tsm_out_if
  import tsm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] merged_value;
  logic                  merge_done;
  logic                  overflow;

  modport source (output valid, merged_value, merge_done, overflow, input ready);
  modport sink   (input valid, merged_value, merge_done, overflow, output ready);
endinterface : tsm_out_if

// File: sv/two_way_sorted_merge.sv
// Two-way sorted merge: top level. Uses tsm_pkg and tsm_in_if/tsm_out_if.
// An accepted element is written, then the heads are read and compared, and each
// merged item it releases takes another head read and compare/emit; a full-queue
// drop emits an overflow item. One item in flight: no new element is taken until
// the FSM is back in idle, and output stalls hold it. Reset (async, active low) clears counts,
// pointers, end flags and the FSM; queue memories are not cleared.
module two_way_sorted_merge
  import tsm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = ListDepthDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsm_in_if.sink    in_i,
  tsm_out_if.source out_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(LIST_DEPTH);
  localparam logic [CW-1:0] CntOne  = CW'(1);
  localparam logic [AW-1:0] PtrLast = AW'(LIST_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE, // waiting for an element
    S_OVF,  // overflow item waits for the output register
    S_READ, // heads being read from both queues
    S_EVAL  // heads valid: compare and emit at most one item
  } state_e;

  // Queue storage, one memory per list, circular buffers
  logic [VALUE_BITS-1:0] mem_first [LIST_DEPTH];
  logic [VALUE_BITS-1:0] mem_second[LIST_DEPTH];
  logic [VALUE_BITS-1:0] head_first_q, head_second_q;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_first_q, cnt_first_d, cnt_second_q, cnt_second_d;
  logic [AW-1:0]   wp_first_q, wp_first_d, wp_second_q, wp_second_d;
  logic [AW-1:0]   rp_first_q, rp_first_d, rp_second_q, rp_second_d;
  logic            end_first_q, end_first_d, end_second_q, end_second_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;
  logic                  out_done_q, out_done_d;
  logic                  out_ovf_q, out_ovf_d;

  logic in_acc, out_free;
  logic wr_first, wr_second;
  logic first_lt, pop_first, pop_second, last_pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + AW'(1);
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  // Output register is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_value_q;
  assign out_o.merge_done   = out_done_q;
  assign out_o.overflow     = out_ovf_q;

  // Pushes only happen for a list still open and not full
  assign wr_first  = in_acc && !in_i.kind && !end_first_q && (cnt_first_q != CntFull);
  assign wr_second = in_acc && in_i.kind && !end_second_q && (cnt_second_q != CntFull);

  // Merge rule on the registered heads; tie goes to the second list
  assign first_lt   = head_first_q < head_second_q;
  assign pop_first  = (cnt_first_q != '0) &&
                      (((cnt_second_q != '0) && first_lt) ||
                       ((cnt_second_q == '0) && end_second_q));
  assign pop_second = (cnt_second_q != '0) &&
                      (((cnt_first_q != '0) && !first_lt) ||
                       ((cnt_first_q == '0) && end_first_q));
  // Final element: both lists ended and exactly one entry left overall
  assign last_pop   = end_first_q && end_second_q &&
                      ((cnt_first_q + cnt_second_q) == CntOne);

  // Memories: write on push, read heads every cycle into registers
  always_ff @(posedge clk_i) begin
    if (wr_first) begin
      mem_first[wp_first_q] <= in_i.value;
    end
    if (wr_second) begin
      mem_second[wp_second_q] <= in_i.value;
    end
    head_first_q  <= mem_first[rp_first_q];
    head_second_q <= mem_second[rp_second_q];
  end

  always_comb begin
    state_d      = state_q;
    cnt_first_d  = cnt_first_q;
    cnt_second_d = cnt_second_q;
    wp_first_d   = wp_first_q;
    wp_second_d  = wp_second_q;
    rp_first_d   = rp_first_q;
    rp_second_d  = rp_second_q;
    end_first_d  = end_first_q;
    end_second_d = end_second_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_done_d   = out_done_q;
    out_ovf_d    = out_ovf_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (wr_first) begin
            wp_first_d  = ptr_inc(wp_first_q);
            cnt_first_d = cnt_first_q + CntOne;
            end_first_d = in_i.end_of_list;
            state_d     = S_READ;
          end else if (wr_second) begin
            wp_second_d  = ptr_inc(wp_second_q);
            cnt_second_d = cnt_second_q + CntOne;
            end_second_d = in_i.end_of_list;
            state_d      = S_READ;
          end else if (in_i.kind ? !end_second_q : !end_first_q) begin
            // open list but full queue: element dropped, flag item
            state_d = S_OVF;
          end
        end
      end
      S_OVF: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_done_d  = 1'b0;
          out_ovf_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!pop_first && !pop_second) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = pop_first ? head_first_q : head_second_q;
          out_done_d  = last_pop;
          out_ovf_d   = 1'b0;
          state_d     = S_READ;
          if (pop_first) begin
            rp_first_d  = ptr_inc(rp_first_q);
            cnt_first_d = cnt_first_q - CntOne;
          end else begin
            rp_second_d  = ptr_inc(rp_second_q);
            cnt_second_d = cnt_second_q - CntOne;
          end
          if (last_pop) begin
            // merge complete: clear for the next pair of lists
            cnt_first_d  = '0;
            cnt_second_d = '0;
            wp_first_d   = '0;
            wp_second_d  = '0;
            rp_first_d   = '0;
            rp_second_d  = '0;
            end_first_d  = 1'b0;
            end_second_d = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_first_q  <= '0;
      cnt_second_q <= '0;
      wp_first_q   <= '0;
      wp_second_q  <= '0;
      rp_first_q   <= '0;
      rp_second_q  <= '0;
      end_first_q  <= 1'b0;
      end_second_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_first_q  <= cnt_first_d;
      cnt_second_q <= cnt_second_d;
      wp_first_q   <= wp_first_d;
      wp_second_q  <= wp_second_d;
      rp_first_q   <= rp_first_d;
      rp_second_q  <= rp_second_d;
      end_first_q  <= end_first_d;
      end_second_q <= end_second_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_done_q  <= out_done_d;
    out_ovf_q   <= out_ovf_d;
  end

endmodule : two_way_sorted_merge
